FILE: hdl/gcr_pkg.sv
// ---------------------------------------------------------------------------
// gcr_pkg: shared types and constants of the glyph column rasterizer
// Holds the fixed 6x8 font column table and the sizes derived from it.
// ---------------------------------------------------------------------------
`default_nettype none

package gcr_pkg;

    localparam int ROM_DEPTH = 570;
    localparam int ROM_AW    = 11;
    localparam int ROM_IW    = 10;
    localparam int MAX_OUT   = 48;

    typedef logic [7:0]        t_rom_byte;
    typedef logic [ROM_AW-1:0] t_rom_addr;

    // Color codes of the pixel channel.
    localparam logic [1:0] COLOR_BLACK  = 2'd0;
    localparam logic [1:0] COLOR_WHITE  = 2'd1;
    localparam logic [1:0] COLOR_INVERT = 2'd2;

    // One byte per glyph column, bit j is row j, codes 32 to 126.
    localparam t_rom_byte C_GLYPH_ROM [ROM_DEPTH] = '{
        8'h00,8'h00,8'h00,8'h00,8'h00,8'h00, 8'h00,8'h00,8'h5F,8'h00,8'h00,8'h00,
        8'h00,8'h07,8'h00,8'h07,8'h00,8'h00, 8'h14,8'h7F,8'h14,8'h7F,8'h14,8'h00,
        8'h24,8'h2A,8'h7F,8'h2A,8'h12,8'h00, 8'h23,8'h13,8'h08,8'h64,8'h62,8'h00,
        8'h36,8'h49,8'h55,8'h22,8'h50,8'h00, 8'h00,8'h05,8'h03,8'h00,8'h00,8'h00,
        8'h00,8'h1C,8'h22,8'h41,8'h00,8'h00, 8'h00,8'h41,8'h22,8'h1C,8'h00,8'h00,
        8'h08,8'h2A,8'h1C,8'h2A,8'h08,8'h00, 8'h08,8'h08,8'h3E,8'h08,8'h08,8'h00,
        8'h00,8'h50,8'h30,8'h00,8'h00,8'h00, 8'h08,8'h08,8'h08,8'h08,8'h08,8'h00,
        8'h00,8'h60,8'h60,8'h00,8'h00,8'h00, 8'h20,8'h10,8'h08,8'h04,8'h02,8'h00,
        8'h3E,8'h51,8'h49,8'h45,8'h3E,8'h00, 8'h00,8'h42,8'h7F,8'h40,8'h00,8'h00,
        8'h42,8'h61,8'h51,8'h49,8'h46,8'h00, 8'h21,8'h41,8'h45,8'h4B,8'h31,8'h00,
        8'h18,8'h14,8'h12,8'h7F,8'h10,8'h00, 8'h27,8'h45,8'h45,8'h45,8'h39,8'h00,
        8'h3C,8'h4A,8'h49,8'h49,8'h30,8'h00, 8'h01,8'h71,8'h09,8'h05,8'h03,8'h00,
        8'h36,8'h49,8'h49,8'h49,8'h36,8'h00, 8'h06,8'h49,8'h49,8'h29,8'h1E,8'h00,
        8'h00,8'h36,8'h36,8'h00,8'h00,8'h00, 8'h00,8'h56,8'h36,8'h00,8'h00,8'h00,
        8'h00,8'h08,8'h14,8'h22,8'h41,8'h00, 8'h14,8'h14,8'h14,8'h14,8'h14,8'h00,
        8'h41,8'h22,8'h14,8'h08,8'h00,8'h00, 8'h02,8'h01,8'h51,8'h09,8'h06,8'h00,
        8'h32,8'h49,8'h79,8'h41,8'h3E,8'h00,
        8'h7E,8'h11,8'h11,8'h11,8'h7E,8'h00, 8'h7F,8'h49,8'h49,8'h49,8'h36,8'h00,
        8'h3E,8'h41,8'h41,8'h41,8'h22,8'h00, 8'h7F,8'h41,8'h41,8'h22,8'h1C,8'h00,
        8'h7F,8'h49,8'h49,8'h49,8'h41,8'h00, 8'h7F,8'h09,8'h09,8'h01,8'h01,8'h00,
        8'h3E,8'h41,8'h41,8'h51,8'h32,8'h00, 8'h7F,8'h08,8'h08,8'h08,8'h7F,8'h00,
        8'h00,8'h41,8'h7F,8'h41,8'h00,8'h00, 8'h20,8'h40,8'h41,8'h3F,8'h01,8'h00,
        8'h7F,8'h08,8'h14,8'h22,8'h41,8'h00, 8'h7F,8'h40,8'h40,8'h40,8'h40,8'h00,
        8'h7F,8'h02,8'h04,8'h02,8'h7F,8'h00, 8'h7F,8'h04,8'h08,8'h10,8'h7F,8'h00,
        8'h3E,8'h41,8'h41,8'h41,8'h3E,8'h00, 8'h7F,8'h09,8'h09,8'h09,8'h06,8'h00,
        8'h3E,8'h41,8'h51,8'h21,8'h5E,8'h00, 8'h7F,8'h09,8'h19,8'h29,8'h46,8'h00,
        8'h46,8'h49,8'h49,8'h49,8'h31,8'h00, 8'h01,8'h01,8'h7F,8'h01,8'h01,8'h00,
        8'h3F,8'h40,8'h40,8'h40,8'h3F,8'h00, 8'h1F,8'h20,8'h40,8'h20,8'h1F,8'h00,
        8'h7F,8'h20,8'h18,8'h20,8'h7F,8'h00, 8'h63,8'h14,8'h08,8'h14,8'h63,8'h00,
        8'h03,8'h04,8'h78,8'h04,8'h03,8'h00, 8'h61,8'h51,8'h49,8'h45,8'h43,8'h00,
        8'h00,8'h00,8'h7F,8'h41,8'h41,8'h00, 8'h02,8'h04,8'h08,8'h10,8'h20,8'h00,
        8'h41,8'h41,8'h7F,8'h00,8'h00,8'h00, 8'h04,8'h02,8'h01,8'h02,8'h04,8'h00,
        8'h40,8'h40,8'h40,8'h40,8'h40,8'h00, 8'h00,8'h01,8'h02,8'h04,8'h00,8'h00,
        8'h20,8'h54,8'h54,8'h54,8'h78,8'h00, 8'h7F,8'h48,8'h44,8'h44,8'h38,8'h00,
        8'h38,8'h44,8'h44,8'h44,8'h20,8'h00, 8'h38,8'h44,8'h44,8'h48,8'h7F,8'h00,
        8'h38,8'h54,8'h54,8'h54,8'h18,8'h00, 8'h08,8'h7E,8'h09,8'h01,8'h02,8'h00,
        8'h0C,8'h52,8'h52,8'h52,8'h3E,8'h00, 8'h7F,8'h08,8'h04,8'h04,8'h78,8'h00,
        8'h00,8'h44,8'h7D,8'h40,8'h00,8'h00, 8'h20,8'h40,8'h44,8'h3D,8'h00,8'h00,
        8'h00,8'h7F,8'h10,8'h28,8'h44,8'h00, 8'h00,8'h41,8'h7F,8'h40,8'h00,8'h00,
        8'h7C,8'h04,8'h18,8'h04,8'h78,8'h00, 8'h7C,8'h08,8'h04,8'h04,8'h78,8'h00,
        8'h38,8'h44,8'h44,8'h44,8'h38,8'h00, 8'h7C,8'h14,8'h14,8'h14,8'h08,8'h00,
        8'h08,8'h14,8'h14,8'h18,8'h7C,8'h00, 8'h7C,8'h08,8'h04,8'h04,8'h08,8'h00,
        8'h48,8'h54,8'h54,8'h54,8'h20,8'h00, 8'h04,8'h3F,8'h44,8'h40,8'h20,8'h00,
        8'h3C,8'h40,8'h40,8'h20,8'h7C,8'h00, 8'h1C,8'h20,8'h40,8'h20,8'h1C,8'h00,
        8'h3C,8'h40,8'h30,8'h40,8'h3C,8'h00, 8'h44,8'h28,8'h10,8'h28,8'h44,8'h00,
        8'h0C,8'h50,8'h50,8'h50,8'h3C,8'h00, 8'h44,8'h64,8'h54,8'h4C,8'h44,8'h00,
        8'h00,8'h08,8'h36,8'h41,8'h00,8'h00, 8'h00,8'h00,8'h7F,8'h00,8'h00,8'h00,
        8'h00,8'h41,8'h36,8'h08,8'h00,8'h00, 8'h08,8'h04,8'h08,8'h10,8'h08,8'h00
    };

endpackage

`default_nettype wire

FILE: hdl/gcr_if.sv
// ---------------------------------------------------------------------------
// gcr_if: valid/ready channels of the glyph column rasterizer
// The character channel carries one glyph request per word, the pixel
// channel one pixel write or marker per word.
// ---------------------------------------------------------------------------
`default_nettype none

interface gcr_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic [7:0] origin_x;
    logic [7:0] origin_y;
    logic [1:0] draw_color;

    modport source (output valid, char_code, origin_x, origin_y, draw_color,
                    input ready);
    modport sink   (input valid, char_code, origin_x, origin_y, draw_color,
                    output ready);
endinterface

interface gcr_pix_if;
    logic       valid;
    logic       ready;
    logic       pixel_valid;
    logic [7:0] pixel_x;
    logic [7:0] pixel_y;
    logic [1:0] pixel_color;
    logic [2:0] advance_width;
    logic       last;

    modport source (output valid, pixel_valid, pixel_x, pixel_y, pixel_color,
                    advance_width, last, input ready);
    modport sink   (input valid, pixel_valid, pixel_x, pixel_y, pixel_color,
                    advance_width, last, output ready);
endinterface

`default_nettype wire

FILE: hdl/gcr_font_rom.sv
// ---------------------------------------------------------------------------
// gcr_font_rom: font column memory with registered read
// Returns one glyph column byte per read, registered; addresses past the
// table read as zero. The data holds until the next read.
// ---------------------------------------------------------------------------
`default_nettype none

module gcr_font_rom (
    input  wire logic               i_clk,
    input  wire logic               i_rd_en,
    input  wire gcr_pkg::t_rom_addr i_addr,
    output      gcr_pkg::t_rom_byte o_data
);
    import gcr_pkg::*;

    t_rom_byte r_data;

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            if (i_addr < ROM_AW'(ROM_DEPTH)) begin
                r_data <= C_GLYPH_ROM[i_addr[ROM_IW-1:0]];
            end else begin
                r_data <= '0;
            end
        end
    end

    assign o_data = r_data;

endmodule

`default_nettype wire

FILE: hdl/glyph_column_rasterizer.sv
// Sequence: a drawn glyph passes IDLE, then READ and SCAN for every column, then FINISH,
// and the pixel sink can stall it; a rejected code goes from IDLE straight to FINISH. Rows
// are scanned one per cycle unless the sink stalls, and each column first reads the font memory.
// Ready is high only when idle, so a new character is taken only after the last one closes.
// Reset (synchronous, active low) returns the sequencer to idle and empties
// the pending and output word registers.
// ---------------------------------------------------------------------------
// glyph_column_rasterizer: 6x8 font character generator
// Expands one character into pixel writes, column by column and row by row,
// from a fixed font column memory.
// ---------------------------------------------------------------------------
`default_nettype none

module glyph_column_rasterizer #(
    parameter int GLYPH_WIDTH  = 6,
    parameter int GLYPH_HEIGHT = 8,
    parameter int FIRST_CODE   = 32,
    parameter int LAST_CODE    = 126
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    gcr_char_if.sink   i_char,
    gcr_pix_if.source  o_pix
);
    import gcr_pkg::*;

    // Column and row counters index up to eight columns and rows.
    localparam logic [2:0] LAST_COL = 3'(GLYPH_WIDTH - 1);
    localparam logic [2:0] LAST_ROW = 3'(GLYPH_HEIGHT - 1);
    localparam logic [2:0] ADV      = 3'(GLYPH_WIDTH);
    localparam logic [7:0] FIRST_C  = 8'(FIRST_CODE);
    localparam logic [7:0] LAST_C   = 8'(LAST_CODE);

    // The sequencer: READ issues a column fetch, SCAN walks that column's rows
    // one per cycle unless the output stalls, FINISH closes the character with its last word.
    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_SCAN,
        S_FINISH
    } t_state;

    t_state     r_state;
    t_rom_addr  r_base;
    logic [2:0] r_col;
    logic [2:0] r_row;
    logic [5:0] r_count;
    logic [7:0] r_ox;
    logic [7:0] r_oy;
    logic [1:0] r_color;
    logic       r_inv;
    logic       r_reject;

    // A generated pixel waits in the pending register until the next one
    // appears, since only then is it known not to be the last word.
    logic       r_pend_v;
    logic [7:0] r_pend_x;
    logic [7:0] r_pend_y;
    logic [1:0] r_pend_c;

    // Output word register.
    logic       r_out_v;
    logic       r_out_pv;
    logic [7:0] r_out_x;
    logic [7:0] r_out_y;
    logic [1:0] r_out_c;
    logic [2:0] r_out_adv;
    logic       r_out_last;

    t_rom_byte  rom_data;
    t_rom_addr  rom_addr;
    logic       rom_rd;
    logic       accept;
    logic       in_range;
    logic       out_free;
    logic       out_load;
    logic       bit_set;
    logic       emit;
    logic [7:0] pix_x;
    logic [7:0] pix_y;

    gcr_font_rom u_rom (
        .i_clk   (i_clk),
        .i_rd_en (rom_rd),
        .i_addr  (rom_addr),
        .o_data  (rom_data)
    );

    assign rom_rd   = (r_state == S_READ);
    assign rom_addr = r_base + ROM_AW'(r_col);

    assign accept   = i_char.valid && i_char.ready;
    assign in_range = (i_char.char_code >= FIRST_C) && (i_char.char_code <= LAST_C);
    // The output register can take a word when it is empty or being drained.
    assign out_free = !r_out_v || o_pix.ready;

    // Below the cap, a set bit always writes; a clear bit writes black unless inverting.
    // Words beyond the cap of MAX_OUT are dropped.
    assign bit_set  = rom_data[r_row];
    assign emit     = (bit_set || !r_inv) && (r_count < 6'(MAX_OUT));
    assign pix_x    = r_ox + 8'(r_col);
    assign pix_y    = r_oy + 8'(r_row);

    // A word enters the output register when a new pixel pushes the pending
    // one out, or when the character closes.
    assign out_load = out_free && (((r_state == S_SCAN) && emit && r_pend_v) ||
                                   (r_state == S_FINISH));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            r_out_v <= out_load || (r_out_v && !o_pix.ready);
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_ox     <= i_char.origin_x;
                        r_oy     <= i_char.origin_y;
                        r_inv    <= i_char.draw_color[1];
                        r_color  <= i_char.draw_color[1] ? COLOR_INVERT
                                                         : i_char.draw_color;
                        r_base   <= ROM_AW'((ROM_AW'(i_char.char_code) - ROM_AW'(FIRST_C))
                                            * ROM_AW'(GLYPH_WIDTH));
                        r_col    <= '0;
                        r_row    <= '0;
                        r_count  <= '0;
                        r_pend_v <= 1'b0;
                        r_reject <= !in_range;
                        r_state  <= in_range ? S_READ : S_FINISH;
                    end
                end
                S_READ: begin
                    r_row   <= '0;
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    // Stall only when the pending pixel must move out first.
                    if (!(emit && r_pend_v && !out_free)) begin
                        if (emit) begin
                            if (r_pend_v) begin
                                r_out_pv   <= 1'b1;
                                r_out_x    <= r_pend_x;
                                r_out_y    <= r_pend_y;
                                r_out_c    <= r_pend_c;
                                r_out_adv  <= '0;
                                r_out_last <= 1'b0;
                            end
                            r_pend_v <= 1'b1;
                            r_pend_x <= pix_x;
                            r_pend_y <= pix_y;
                            r_pend_c <= bit_set ? r_color : COLOR_BLACK;
                            r_count  <= r_count + 6'd1;
                        end
                        if (r_row == LAST_ROW) begin
                            if (r_col == LAST_COL) begin
                                r_state <= S_FINISH;
                            end else begin
                                r_col   <= r_col + 3'd1;
                                r_state <= S_READ;
                            end
                        end else begin
                            r_row <= r_row + 3'd1;
                        end
                    end
                end
                S_FINISH: begin
                    // The held pixel becomes the last word; with none held a
                    // marker word closes the character.
                    if (out_free) begin
                        r_out_last <= 1'b1;
                        r_out_adv  <= r_reject ? 3'd0 : ADV;
                        if (r_pend_v) begin
                            r_out_pv <= 1'b1;
                            r_out_x  <= r_pend_x;
                            r_out_y  <= r_pend_y;
                            r_out_c  <= r_pend_c;
                        end else begin
                            r_out_pv <= 1'b0;
                            r_out_x  <= '0;
                            r_out_y  <= '0;
                            r_out_c  <= COLOR_BLACK;
                        end
                        r_pend_v <= 1'b0;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_char.ready        = (r_state == S_IDLE);
    assign o_pix.valid         = r_out_v;
    assign o_pix.pixel_valid   = r_out_pv;
    assign o_pix.pixel_x       = r_out_x;
    assign o_pix.pixel_y       = r_out_y;
    assign o_pix.pixel_color   = r_out_c;
    assign o_pix.advance_width = r_out_adv;
    assign o_pix.last          = r_out_last;

endmodule

`default_nettype wire
